// ----- design/bfc_pkg.sv -----
// Shared types and codes for the bounded FIFO with close.
`timescale 1ns / 1ps

package bfc_pkg;

	localparam int ACTION_W   = 2;
	localparam int ID_W       = 8;
	localparam int SEQ_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 5;
	localparam int TOTAL_W    = 32;
	localparam int SUM_W      = 64;
	localparam int CAP_W      = 5;
	localparam int PROD_W     = 8;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRODUCER_COUNT = 1'd1;

	localparam logic [CAP_W-1:0]  CAPACITY_RESET  = 5'd8;
	localparam logic [PROD_W-1:0] PRODUCERS_RESET = 8'd2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUT  = 2'd0,
		ACT_GET  = 2'd1,
		ACT_DONE = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PUT_OK       = 3'd0,
		ST_FULL         = 3'd1,
		ST_GOT          = 3'd2,
		ST_EMPTY        = 3'd3,
		ST_CLOSED_EMPTY = 3'd4,
		ST_DONE_OK      = 3'd5,
		ST_EXTRA        = 3'd6
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [SEQ_W-1:0] seq;
	} entry_t;

endpackage

// ----- design/bounded_fifo_with_close_core.sv -----
// A word accepted passes the input register, then the result register. Throughput: one
// put, get or done word per cycle while result_stall is low; the entry store has one write
// and one registered read port, and the running sum folds in as each result leaves.
// Reset: pointers, fill, totals and the closed flag clear, capacity loads 8 and
// producers remaining loads 2; the entry store is not cleared.
`timescale 1ns / 1ps

module bounded_fifo_with_close_core #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [bfc_pkg::ACTION_W-1:0]    action,
	input  logic [bfc_pkg::ID_W-1:0]        producer_id,
	input  logic [bfc_pkg::SEQ_W-1:0]       sequence_req,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [bfc_pkg::STATUS_W-1:0]    status,
	output logic [bfc_pkg::ID_W-1:0]        out_producer_id,
	output logic [bfc_pkg::SEQ_W-1:0]       out_sequence,
	output logic [bfc_pkg::COUNT_W-1:0]     fill_count,
	output logic [bfc_pkg::TOTAL_W-1:0]     consumed_total,
	output logic [bfc_pkg::SUM_W-1:0]       sum_of_sequences,
	output logic                            is_closed,
	// configuration
	input  logic                            cfg_write,
	input  logic [bfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import bfc_pkg::*;

	// Pointer width covers the store; compare width also holds DEPTH and any capacity code.
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = (PW + 1 > CAP_W + 1) ? PW + 1 : CAP_W + 1;

	// Move a pointer on by one, back to zero once it would reach the live capacity.
	function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p,
		input logic [CW-1:0] lim);
		logic [CW-1:0] n;
		n = CW'(p) + CW'(1);
		step_ptr = (n >= lim) ? '0 : n[PW-1:0];
	endfunction

	// Configuration and queue state
	logic [CAP_W-1:0]   capacity_q;
	logic [PROD_W-1:0]  remaining_q;
	logic               closed_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [PW-1:0]      wr_ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic [TOTAL_W-1:0] taken_q;
	// Sum of the sequences of every result already handed on
	logic [SUM_W-1:0]   sum_q;

	// Entry store: one write, one registered read
	entry_t             store_q [DEPTH];

	// Input register
	logic               valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [ID_W-1:0]    id_s1;
	logic [SEQ_W-1:0]   seq_s1;

	// Result register
	logic               valid_s2;
	status_t            status_s2;
	logic [COUNT_W-1:0] fill_s2;
	logic [TOTAL_W-1:0] taken_s2;
	logic               closed_s2;
	entry_t             rdata_s2;

	// Step logic
	logic [CW-1:0]      cap_ext;
	logic [CW-1:0]      cap_floor;
	logic [CW-1:0]      ecap;
	status_t            st_n;
	logic [PW-1:0]      rd_ptr_n;
	logic [PW-1:0]      wr_ptr_n;
	logic [COUNT_W-1:0] count_n;
	logic [TOTAL_W-1:0] taken_n;
	logic [PROD_W-1:0]  remaining_n;
	logic               closed_n;
	logic               store_we;
	logic               store_re;
	logic               advance_s1;
	logic               result_take;
	logic               got_s2;

	// The first word moves on whenever the result register is free or being emptied.
	assign result_take = valid_s2 && !result_stall;
	assign advance_s1  = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall  = valid_s1 && !advance_s1;

	// Clamp capacity to 1..DEPTH.
	assign cap_ext   = CW'(capacity_q);
	assign cap_floor = (capacity_q == '0) ? CW'(1) : cap_ext;
	assign ecap      = (cap_floor > CW'(DEPTH)) ? CW'(DEPTH) : cap_floor;

	always_comb begin
		st_n        = ST_EXTRA;
		rd_ptr_n    = rd_ptr_q;
		wr_ptr_n    = wr_ptr_q;
		count_n     = count_q;
		taken_n     = taken_q;
		remaining_n = remaining_q;
		closed_n    = closed_q;
		store_we    = 1'b0;
		store_re    = 1'b0;
		unique case (action_t'(action_s1))
			ACT_PUT: begin
				// Reject while held entries reach the capacity, even after it was lowered.
				if (CW'(count_q) >= ecap) begin
					st_n = ST_FULL;
				end else begin
					store_we = 1'b1;
					wr_ptr_n = step_ptr(wr_ptr_q, ecap);
					count_n  = count_q + COUNT_W'(1);
					st_n     = ST_PUT_OK;
				end
			end
			ACT_GET: begin
				if (count_q == '0) begin
					st_n = closed_q ? ST_CLOSED_EMPTY : ST_EMPTY;
				end else begin
					store_re = 1'b1;
					rd_ptr_n = step_ptr(rd_ptr_q, ecap);
					count_n  = count_q - COUNT_W'(1);
					taken_n  = taken_q + TOTAL_W'(1);
					st_n     = ST_GOT;
				end
			end
			ACT_DONE: begin
				// A done with no producer left is flagged and dropped.
				if (remaining_q == '0) begin
					st_n = ST_EXTRA;
				end else begin
					remaining_n = remaining_q - PROD_W'(1);
					if (remaining_q == PROD_W'(1)) begin
						closed_n = 1'b1;
					end
					st_n = ST_DONE_OK;
				end
			end
			default: begin
				// Unused action code: change nothing.
				st_n = ST_EXTRA;
			end
		endcase
	end

	// Control state, configuration and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAPACITY_RESET;
			remaining_q <= PRODUCERS_RESET;
			closed_q    <= 1'b0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			count_q     <= '0;
			taken_q     <= '0;
			sum_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_CAPACITY: begin
						capacity_q <= cfg_data[CAP_W-1:0];
					end
					REG_PRODUCER_COUNT: begin
						// Reload the countdown; a count of zero closes at once.
						remaining_q <= cfg_data[PROD_W-1:0];
						closed_q    <= (cfg_data[PROD_W-1:0] == '0);
					end
					default: begin
					end
				endcase
			end else if (advance_s1) begin
				rd_ptr_q    <= rd_ptr_n;
				wr_ptr_q    <= wr_ptr_n;
				count_q     <= count_n;
				taken_q     <= taken_n;
				remaining_q <= remaining_n;
				closed_q    <= closed_n;
			end

			// Fold a taken sequence into the sum as its result leaves.
			if (result_take && got_s2) begin
				sum_q <= sum_q + SUM_W'(rdata_s2.seq);
			end

			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end

			if (advance_s1) begin
				valid_s2 <= 1'b1;
			end else if (result_take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			action_s1 <= action;
			id_s1     <= producer_id;
			seq_s1    <= sequence_req;
		end
		if (advance_s1) begin
			status_s2 <= st_n;
			fill_s2   <= count_n;
			taken_s2  <= taken_n;
			closed_s2 <= closed_n;
		end
	end

	// Entry store: write at the write pointer, registered read at the read pointer
	always_ff @(posedge clk) begin
		if (advance_s1 && store_we) begin
			store_q[wr_ptr_q] <= '{id: id_s1, seq: seq_s1};
		end
		if (advance_s1 && store_re) begin
			rdata_s2 <= store_q[rd_ptr_q];
		end
	end

	// Result word: the entry fields are zero unless an entry was taken
	assign got_s2           = (status_s2 == ST_GOT);
	assign result_valid     = valid_s2;
	assign status           = status_s2;
	assign out_producer_id  = got_s2 ? rdata_s2.id : '0;
	assign out_sequence     = got_s2 ? rdata_s2.seq : '0;
	assign fill_count       = fill_s2;
	assign consumed_total   = taken_s2;
	assign sum_of_sequences = sum_q + (got_s2 ? SUM_W'(rdata_s2.seq) : '0);
	assign is_closed        = closed_s2;

endmodule

// ----- verif/bounded_fifo_with_close_core_tb.sv -----
// Self-checking testbench for the bounded FIFO with close: shadow model, driver and monitor.
`timescale 1ns / 1ps

module bounded_fifo_with_close_core_tb;

	import bfc_pkg::*;

	localparam int                    FIFO_DEPTH = 16;
	// action code the block does not define; it must report an extra done
	localparam logic [ACTION_W-1:0]   ACT_UNUSED = 2'd3;

	typedef struct {
		logic [ACTION_W-1:0] act;
		logic [ID_W-1:0]     id;
		logic [SEQ_W-1:0]    seq;
	} word_t;

	typedef struct {
		status_t             status;
		logic [ID_W-1:0]     id;
		logic [SEQ_W-1:0]    seq;
		logic [COUNT_W-1:0]  fill;
		logic [TOTAL_W-1:0]  total;
		logic [SUM_W-1:0]    sum;
		logic                closed;
	} result_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	logic [ACTION_W-1:0]   action       = ACT_PUT;
	logic [ID_W-1:0]       producer_id  = '0;
	logic [SEQ_W-1:0]      sequence_req = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [ID_W-1:0]       out_producer_id;
	logic [SEQ_W-1:0]      out_sequence;
	logic [COUNT_W-1:0]    fill_count;
	logic [TOTAL_W-1:0]    consumed_total;
	logic [SUM_W-1:0]      sum_of_sequences;
	logic                  is_closed;
	logic                  cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = REG_CAPACITY;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// shadow copy of the block's registers and state
	logic [CAP_W-1:0]      shadow_cap       = CAPACITY_RESET;
	logic [PROD_W-1:0]     shadow_remaining = PRODUCERS_RESET;
	logic                  shadow_closed    = 1'b0;
	logic [ID_W-1:0]       shadow_id  [FIFO_DEPTH];
	logic [SEQ_W-1:0]      shadow_seq [FIFO_DEPTH];
	int                    shadow_rp        = 0;
	int                    shadow_wp        = 0;
	logic [COUNT_W-1:0]    shadow_count     = '0;
	logic [TOTAL_W-1:0]    shadow_taken     = '0;
	logic [SUM_W-1:0]      shadow_sum       = '0;

	word_t                 pending_words[$];
	result_t               due_results[$];
	word_t                 next_word;
	int                    words_offered = 0;
	int                    words_taken   = 0;
	int                    results_seen  = 0;
	int                    error_count   = 0;
	int                    phase_count   = 0;
	int                    status_hits[8];
	bit                    drain_hold    = 1'b0;
	int                    burst_left    = 1;
	int                    gap_left      = 0;
	int                    stall_mode    = 0;
	int                    stall_left    = 0;
	int                    stall_cycles  = 0;

	bounded_fifo_with_close_core #(
		.DEPTH(FIFO_DEPTH)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.action           (action),
		.producer_id      (producer_id),
		.sequence_req     (sequence_req),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.status           (status),
		.out_producer_id  (out_producer_id),
		.out_sequence     (out_sequence),
		.fill_count       (fill_count),
		.consumed_total   (consumed_total),
		.sum_of_sequences (sum_of_sequences),
		.is_closed        (is_closed),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #2 clk = ~clk;

	// capacity 0 behaves as 1, anything past the store depth as the full depth
	function automatic int eff_cap();
		int c;
		c = int'(shadow_cap);
		if (c == 0)
			c = 1;
		if (c > FIFO_DEPTH)
			c = FIFO_DEPTH;
		return c;
	endfunction

	// wrap to slot 0 once the next slot would reach the effective capacity
	function automatic int next_slot(input int p);
		int n;
		n = p + 1;
		return (n >= eff_cap()) ? 0 : n;
	endfunction

	// advance the shadow FIFO by one accepted word and queue the result it owes
	task automatic step_shadow(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id,
			input logic [SEQ_W-1:0] seq);
		result_t r;
		int      slot;
		r.status = ST_EXTRA;
		r.id     = '0;
		r.seq    = '0;
		case (act)
			ACT_PUT: begin
				if (shadow_count >= eff_cap()) begin
					r.status = ST_FULL;
				end else begin
					slot             = shadow_wp % FIFO_DEPTH;
					shadow_id[slot]  = id;
					shadow_seq[slot] = seq;
					shadow_wp        = next_slot(slot);
					shadow_count     = shadow_count + 1'b1;
					r.status         = ST_PUT_OK;
				end
			end
			ACT_GET: begin
				if (shadow_count == 0) begin
					r.status = shadow_closed ? ST_CLOSED_EMPTY : ST_EMPTY;
				end else begin
					slot         = shadow_rp % FIFO_DEPTH;
					r.id         = shadow_id[slot];
					r.seq        = shadow_seq[slot];
					shadow_rp    = next_slot(slot);
					shadow_count = shadow_count - 1'b1;
					shadow_taken = shadow_taken + 1'b1;
					shadow_sum   = shadow_sum + {32'd0, r.seq};
					r.status     = ST_GOT;
				end
			end
			ACT_DONE: begin
				if (shadow_remaining != 0) begin
					shadow_remaining = shadow_remaining - 1'b1;
					if (shadow_remaining == 0)
						shadow_closed = 1'b1;
					r.status = ST_DONE_OK;
				end
			end
			default: r.status = ST_EXTRA;
		endcase
		r.fill   = shadow_count;
		r.total  = shadow_taken;
		r.sum    = shadow_sum;
		r.closed = shadow_closed;
		due_results.push_back(r);
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// accept side: a word moves when valid is high and stall is low
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			step_shadow(action, producer_id, sequence_req);
			words_taken++;
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				exp_r = due_results.pop_front();
				check_field("status", status, exp_r.status);
				check_field("out_producer_id", out_producer_id, exp_r.id);
				check_field("out_sequence", out_sequence, exp_r.seq);
				check_field("fill_count", fill_count, exp_r.fill);
				check_field("consumed_total", consumed_total, exp_r.total);
				check_field("sum_of_sequences", sum_of_sequences, exp_r.sum);
				check_field("is_closed", is_closed, exp_r.closed);
				status_hits[exp_r.status]++;
			end
			results_seen++;
		end
	end

	// driver: bursts of words with random gaps; hold a stalled word unchanged
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (item_valid && words_taken != words_offered) begin
			// hold: the word on the port has not been taken yet
		end else if (drain_hold) begin
			// pause until every owed result has come back
			if (due_results.size() == 0 && words_taken == words_offered)
				drain_hold = 1'b0;
			item_valid <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left--;
			item_valid <= 1'b0;
		end else if (pending_words.size() > 0) begin
			next_word = pending_words.pop_front();
			action       <= next_word.act;
			producer_id  <= next_word.id;
			sequence_req <= next_word.seq;
			item_valid   <= 1'b1;
			words_offered++;
			if (words_offered % 257 == 128)
				drain_hold = 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 24);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end else begin
			item_valid <= 1'b0;
		end
	end

	// receiver stall: switch between free flow, light, heavy and long-burst stalling
	always @(negedge clk) begin
		if (stall_cycles == 0) begin
			stall_mode   = $urandom_range(0, 3);
			stall_cycles = $urandom_range(16, 64);
		end else begin
			stall_cycles--;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 9) < 7);
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					result_stall <= 1'b1;
				end else begin
					if ($urandom_range(0, 5) == 0)
						stall_left = $urandom_range(4, 12);
					result_stall <= 1'b0;
				end
			end
		endcase
	end

	task automatic push_word(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id,
			input logic [SEQ_W-1:0] seq);
		word_t w;
		w.act = act;
		w.id  = id;
		w.seq = seq;
		pending_words.push_back(w);
	endtask

	// wait until no word is pending or in flight, then let the pipeline settle
	task automatic wait_idle();
		while (!(pending_words.size() == 0 && words_taken == words_offered &&
				due_results.size() == 0))
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == REG_CAPACITY) begin
			shadow_cap = data[CAP_W-1:0];
		end else begin
			shadow_remaining = data;
			shadow_closed    = (data == 0);
		end
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// reconfigure while idle, then queue a weighted mix of random words
	task automatic run_phase(input int cap, input int pc, input int n, input int wput,
			input int wget, input int wdone, input int wbad);
		logic [CFG_DATA_W-1:0] data;
		logic [SEQ_W-1:0]      seq;
		int                    pick;
		wait_idle();
		// upper data bits are ignored by the capacity register; toggle them anyway
		data = CFG_DATA_W'($urandom);
		data[CAP_W-1:0] = CAP_W'(cap);
		write_reg(REG_CAPACITY, data);
		if (pc >= 0)
			write_reg(REG_PRODUCER_COUNT, CFG_DATA_W'(pc));
		phase_count++;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, wput + wget + wdone + wbad - 1);
			seq  = $urandom;
			case ($urandom_range(0, 7))
				0: seq = '1;
				1: seq = '0;
				default: ;
			endcase
			if (pick < wput)
				push_word(ACT_PUT, ID_W'($urandom), seq);
			else if (pick < wput + wget)
				push_word(ACT_GET, ID_W'($urandom), seq);
			else if (pick < wput + wget + wdone)
				push_word(ACT_DONE, ID_W'($urandom), seq);
			else
				push_word(ACT_UNUSED, ID_W'($urandom), seq);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: fill every slot once at full depth so later capacity changes
		// can never expose a slot that was never written
		write_reg(REG_CAPACITY, 8'd16);
		write_reg(REG_PRODUCER_COUNT, 8'd2);
		phase_count++;
		push_word(ACT_GET, 8'h00, 32'h0);
		push_word(ACT_PUT, 8'h00, 32'h0000_0000);
		push_word(ACT_PUT, 8'hFF, 32'hFFFF_FFFF);
		push_word(ACT_PUT, 8'hAA, 32'hAAAA_AAAA);
		push_word(ACT_PUT, 8'h55, 32'h5555_5555);
		for (int i = 0; i < 12; i++)
			push_word(ACT_PUT, ID_W'($urandom), $urandom);
		push_word(ACT_PUT, 8'h5A, 32'hDEAD_0001);   // full: rejected
		push_word(ACT_GET, 8'h00, 32'h0);
		push_word(ACT_GET, 8'hFF, 32'hFFFF_FFFF);
		push_word(ACT_DONE, 8'h00, 32'h0);
		push_word(ACT_DONE, 8'h00, 32'h0);          // last producer: close
		push_word(ACT_DONE, 8'h00, 32'h0);          // extra done
		push_word(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF);
		push_word(ACT_PUT, 8'h3C, 32'h1234_5678);   // put after close still lands

		// drain a closed queue past empty at an oversized capacity
		run_phase(31, -1, 60, 1, 6, 1, 0);
		run_phase(1, 3, 80, 3, 3, 1, 1);
		// zero capacity behaves as one; zero producers closes at once
		run_phase(0, 0, 60, 3, 3, 2, 1);
		run_phase(16, 255, 120, 6, 2, 1, 0);
		// capacity lowered while the queue is nearly full
		run_phase(5, 4, 80, 1, 3, 1, 0);
		run_phase(17, 1, 120, 3, 3, 1, 1);
		for (int p = 0; p < 10; p++)
			run_phase(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16),
				$urandom_range(1, 6), 40, $urandom_range(1, 6), $urandom_range(1, 6),
				$urandom_range(0, 2), $urandom_range(0, 1));
		run_phase(16, 8'hA5, 40, 4, 4, 1, 1);

		wait_idle();
		repeat (8) @(posedge clk);
		if (due_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived", due_results.size()));
		$display("Covered %0d words and %0d results over %0d configuration phases.",
			words_offered, results_seen, phase_count);
		$display("Statuses: put %0d full %0d got %0d empty %0d closed %0d done %0d extra %0d.",
			status_hits[ST_PUT_OK], status_hits[ST_FULL], status_hits[ST_GOT],
			status_hits[ST_EMPTY], status_hits[ST_CLOSED_EMPTY], status_hits[ST_DONE_OK],
			status_hits[ST_EXTRA]);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
design/bfc_pkg.sv
design/bounded_fifo_with_close_core.sv
verif/bounded_fifo_with_close_core_tb.sv
